[rtl/sorted_timer_queue_assert.svh]
// Assertion macros for the sorted timer queue.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define STQ_ASSERT_NOW(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("sorted_timer_queue: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define STQ_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("sorted_timer_queue: next-cycle check failed");

`endif

[rtl/stq_pkg.sv]
// Shared types and codes for the sorted timer queue.
// No dependencies; imported by stq_cell and sorted_timer_queue.
package stq_pkg;

	// input commands
	localparam logic [1:0] CMD_SCHEDULE = 2'd0;
	localparam logic [1:0] CMD_RUN      = 2'd1;
	localparam logic [1:0] CMD_ADJUST   = 2'd2;

	// result status codes
	localparam logic [2:0] ST_SCHEDULED = 3'd0;
	localparam logic [2:0] ST_REJECTED  = 3'd1;
	localparam logic [2:0] ST_DUE       = 3'd2;
	localparam logic [2:0] ST_NONE_DUE  = 3'd3;
	localparam logic [2:0] ST_ADJUSTED  = 3'd4;

	// at most this many due entries leave in one run pass
	localparam int MAX_RESULTS = 16;
	localparam int POP_CNT_W   = $clog2(MAX_RESULTS);

	typedef struct packed {
		logic [31:0]        deadline;
		logic [7:0]         tag;
		logic [15:0]        message;
		logic signed [15:0] payload;
	} entry_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP,
		OP_ADJUST
	} cell_op_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		cell_op_t    op;
		entry_t      new_entry;
		logic [30:0] offset;
	} cell_ctl_t;

endpackage

[rtl/stq_cell.sv]
// One slot of the sorted timer queue: holds an entry and its valid bit.
// Depends on stq_pkg; trades entries with its left and right neighbors.
module stq_cell import stq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      left_keep,
	input  logic      left_valid,
	input  entry_t    left_entry,
	input  logic      right_valid,
	input  entry_t    right_entry,
	output logic      keep,
	output logic      valid,
	output entry_t    entry
);

	logic   valid_q;
	entry_t entry_q;
	logic   valid_d;
	entry_t entry_d;

	// entry stays put on insert when its deadline is strictly earlier
	assign keep  = valid_q && (entry_q.deadline < ctl.new_entry.deadline);
	assign valid = valid_q;
	assign entry = entry_q;

	// next-state selection
	always_comb begin
		valid_d = valid_q;
		entry_d = entry_q;
		case (ctl.op)
			OP_INSERT: begin
				if (!keep) begin
					valid_d = valid_q | left_valid;
					entry_d = left_keep ? ctl.new_entry : left_entry;
				end
			end
			OP_POP: begin
				valid_d = right_valid;
				entry_d = right_entry;
			end
			OP_ADJUST: begin
				if (entry_q.deadline < {1'b0, ctl.offset})
					entry_d.deadline = '0;
				else
					entry_d.deadline = entry_q.deadline - {1'b0, ctl.offset};
			end
			default: begin
				valid_d = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= valid_d;
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

[rtl/sorted_timer_queue.sv]
// Sorted timer queue: a row of QUEUE_DEPTH cells kept in deadline order.
// Input channel (in_valid/in_ready) takes a command with its fields; output
// channel (out_valid/out_ready) returns result items with status, due task
// fields, pending and last flags.
// Schedule: deadline = current time + delay_ms (saturating); inserted ahead of
// equal or later deadlines; full queue gives a rejected result.
// Run: one due item per cycle popped from the head cell while the output is not
// stalled, up to 16 per pass; with nothing due a single none-due result is given.
// Adjust: every cell subtracts offset_ms (saturating at zero).
// Flow: an item is taken in the idle state and executed in the exec state once
// the output register is free or being drained; a run pops further due entries
// in the pop state. The output register holds a finished result while the next
// item is taken; a stalled receiver holds execution, not input acceptance.
// Reset clears all cell valid bits, the current time and the handshakes.
module sorted_timer_queue import stq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [7:0]         task_tag,
	input  logic [31:0]        delay_ms,
	input  logic [15:0]        message_id,
	input  logic signed [15:0] payload,
	input  logic [31:0]        now_ms,
	input  logic [30:0]        offset_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [7:0]         due_tag,
	output logic [15:0]        due_message,
	output logic signed [15:0] due_payload,
	output logic               pending,
	output logic               last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP
	} state_t;

	state_t                 state_q;
	logic [1:0]             cmd_q;
	entry_t                 new_q;
	logic [31:0]            now_q;
	logic [30:0]            off_q;
	logic [31:0]            cur_time_q;
	logic [POP_CNT_W-1:0]   pop_cnt_q;

	logic                   out_valid_q;
	logic [2:0]             status_q;
	logic [7:0]             due_tag_q;
	logic [15:0]            due_message_q;
	logic signed [15:0]     due_payload_q;
	logic                   pending_q;
	logic                   last_q;

	logic [32:0]            due_sum;
	logic [31:0]            due_sat;
	logic                   go;
	logic                   emit;
	logic                   full;
	logic                   due0;
	logic                   due1;
	logic                   pop_last;
	cell_ctl_t              ctl;

	logic [QUEUE_DEPTH-1:0] cell_keep;
	logic [QUEUE_DEPTH-1:0] cell_valid;
	entry_t                 cell_entry [QUEUE_DEPTH];

	assign in_ready = (state_q == S_IDLE);

	// saturating deadline at accept time
	assign due_sum = {1'b0, cur_time_q} + {1'b0, delay_ms};
	assign due_sat = due_sum[32] ? '1 : due_sum[31:0];

	// execute when the output register is free or being drained
	assign go       = (state_q != S_IDLE) && (!out_valid_q || out_ready);
	assign emit     = go && ((cmd_q == CMD_SCHEDULE) || (cmd_q == CMD_RUN) ||
		(cmd_q == CMD_ADJUST));
	assign full     = cell_valid[QUEUE_DEPTH-1];
	assign due0     = cell_valid[0] && (cell_entry[0].deadline <= now_q);
	assign due1     = cell_valid[1] && (cell_entry[1].deadline <= now_q);
	assign pop_last = !due1 || (pop_cnt_q == POP_CNT_W'(MAX_RESULTS - 1));

	// cell broadcast
	always_comb begin
		ctl.new_entry = new_q;
		ctl.offset    = off_q;
		ctl.op        = OP_HOLD;
		if (go) begin
			case (cmd_q)
				CMD_SCHEDULE: ctl.op = full ? OP_HOLD : OP_INSERT;
				CMD_RUN:      ctl.op = due0 ? OP_POP : OP_HOLD;
				CMD_ADJUST:   ctl.op = OP_ADJUST;
				default:      ctl.op = OP_HOLD;
			endcase
		end
	end

	// row of cells; the head sees an always-kept, always-valid left side
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   lk;
		logic   lv;
		entry_t le;
		logic   rv;
		entry_t re;
		if (i == 0) begin : g_head
			assign lk = 1'b1;
			assign lv = 1'b1;
			assign le = '0;
		end else begin : g_mid
			assign lk = cell_keep[i-1];
			assign lv = cell_valid[i-1];
			assign le = cell_entry[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign rv = 1'b0;
			assign re = '0;
		end else begin : g_body
			assign rv = cell_valid[i+1];
			assign re = cell_entry[i+1];
		end
		stq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_keep   (lk),
			.left_valid  (lv),
			.left_entry  (le),
			.right_valid (rv),
			.right_entry (re),
			.keep        (cell_keep[i]),
			.valid       (cell_valid[i]),
			.entry       (cell_entry[i])
		);
	end

	// controller: state, command registers and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= CMD_SCHEDULE;
			new_q         <= '0;
			now_q         <= '0;
			off_q         <= '0;
			cur_time_q    <= '0;
			out_valid_q   <= 1'b0;
			pop_cnt_q     <= '0;
			status_q      <= ST_SCHEDULED;
			due_tag_q     <= '0;
			due_message_q <= '0;
			due_payload_q <= '0;
			pending_q     <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			// a new result loads the register, otherwise it drains
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q             <= command;
						new_q.deadline    <= due_sat;
						new_q.tag         <= task_tag;
						new_q.message     <= message_id;
						new_q.payload     <= payload;
						now_q             <= now_ms;
						off_q             <= offset_ms;
						pop_cnt_q         <= '0;
						state_q           <= S_EXEC;
					end
				end
				S_EXEC, S_POP: begin
					if (go) begin
						case (cmd_q)
							CMD_SCHEDULE: begin
								status_q      <= full ? ST_REJECTED : ST_SCHEDULED;
								due_tag_q     <= '0;
								due_message_q <= '0;
								due_payload_q <= '0;
								pending_q     <= 1'b1;
								last_q        <= 1'b1;
								state_q       <= S_IDLE;
							end
							CMD_RUN: begin
								cur_time_q <= now_q;
								if (due0) begin
									status_q      <= ST_DUE;
									due_tag_q     <= cell_entry[0].tag;
									due_message_q <= cell_entry[0].message;
									due_payload_q <= cell_entry[0].payload;
									pending_q     <= 1'b1;
									last_q        <= pop_last;
									pop_cnt_q     <= pop_cnt_q + 1'b1;
									state_q       <= pop_last ? S_IDLE : S_POP;
								end else begin
									status_q      <= ST_NONE_DUE;
									due_tag_q     <= '0;
									due_message_q <= '0;
									due_payload_q <= '0;
									pending_q     <= cell_valid[0];
									last_q        <= 1'b1;
									state_q       <= S_IDLE;
								end
							end
							CMD_ADJUST: begin
								status_q      <= ST_ADJUSTED;
								due_tag_q     <= '0;
								due_message_q <= '0;
								due_payload_q <= '0;
								pending_q     <= cell_valid[0];
								last_q        <= 1'b1;
								state_q       <= S_IDLE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign due_tag     = due_tag_q;
	assign due_message = due_message_q;
	assign due_payload = due_payload_q;
	assign pending     = pending_q;
	assign last        = last_q;

	`include "sorted_timer_queue_assert.svh"

	// occupied cells form a prefix of the row
	`STQ_ASSERT_NOW(a_prefix, 1'b1, (((cell_valid >> 1) & ~cell_valid) == '0))
	// the two head cells stay in deadline order
	`STQ_ASSERT_NOW(a_head_sorted, cell_valid[1], cell_entry[0].deadline <= cell_entry[1].deadline)
	// a continued run pass always finds a due head entry
	`STQ_ASSERT_NOW(a_pop_due, (state_q == S_POP), due0)

endmodule
